>>> rtl/tocu_pkg.sv
// ----------------------------------------------------------------------------
// tocu_pkg: shared types and constants
// Register indexes, channel-stage bookkeeping and the log2 table builder.
// ----------------------------------------------------------------------------
package tocu_pkg;

    localparam int CH_NUM     = 4;
    localparam int SAMPLE_W   = 12;
    localparam int TEMP_W     = 14;
    localparam int LG_W       = 22;
    localparam int LN2_Q16    = 45426;
    localparam int TEMP_MIN   = -4368;
    localparam int TEMP_MAX   = 8191;
    localparam int KELVIN_Q4  = 4368;
    localparam int QBITS      = 14;
    localparam int PRE_STAGES = 8;
    localparam int CH_STAGES  = PRE_STAGES + QBITS + 1;
    localparam int DEN_W      = 35;
    localparam int REM_W      = 45;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REF_RES,
        REG_FULL_SCALE,
        REG_BETA,
        REG_BASE_RES,
        REG_BASE_TEMP,
        REG_TEMP_LIMIT
    } t_cfg_idx;

    typedef enum logic [1:0] {
        RES_CALC,
        RES_MIN,
        RES_MAX
    } t_res;

    typedef struct packed {
        logic [19:0] ref_res;
        logic [11:0] full_scale;
        logic [15:0] beta;
        logic [19:0] base_res;
        logic [12:0] base_temp;
    } t_cfg;

    // log2(1 + i/2^tbits) in Q16 by repeated squaring; elaboration only
    function automatic logic [16:0] lg_entry(int unsigned i, int unsigned tbits);
        logic [63:0] y;
        logic [15:0] fr;
        logic        ip;
        y  = (64'd1 << 30) + (64'(i) << (30 - tbits));
        ip = 1'b0;
        fr = '0;
        if (y >= (64'd1 << 31)) begin
            ip = 1'b1;
            y  = y >> 1;
        end
        for (int b = 0; b < 16; b++) begin
            y  = (y * y) >> 30;
            fr = {fr[14:0], (y >= (64'd1 << 31))};
            if (y >= (64'd1 << 31)) begin
                y = y >> 1;
            end
        end
        return {ip, fr};
    endfunction

endpackage

>>> rtl/tocu_log2.sv
// ----------------------------------------------------------------------------
// tocu_log2: three-stage log2 in Q16
// Leading-one search, normalize and table lookup, then linear interpolation.
// ----------------------------------------------------------------------------
module tocu_log2
    import tocu_pkg::*;
#(
    parameter int LOG_TABLE_BITS = 8
) (
    input  logic            i_clk,
    input  logic [2:0]      i_en,
    input  logic [31:0]     i_x,
    output logic [LG_W-1:0] o_lg
);

    localparam int TBL_SIZE = (1 << LOG_TABLE_BITS) + 1;
    localparam int FRAC_W   = 32 - LOG_TABLE_BITS;

    logic [16:0] w_tbl [TBL_SIZE];

    for (genvar gi = 0; gi < TBL_SIZE; gi++) begin : g_tbl
        assign w_tbl[gi] = lg_entry(gi, LOG_TABLE_BITS);
    end

    logic [4:0]  n_e, r_e, r_e2;
    logic [31:0] r_x;
    logic [63:0] w_sh;
    logic [31:0] w_f;
    logic [LOG_TABLE_BITS:0] w_idx;
    logic [16:0] w_a, w_b;
    logic [16:0] r_a, r_diff;
    logic [FRAC_W-1:0] r_rem;
    logic [16+FRAC_W:0] w_prod;
    logic [LG_W-1:0] r_lg;

    always_comb begin
        n_e = '0;
        for (int k = 0; k < 32; k++) begin
            if (i_x[k]) n_e = 5'(k);
        end
    end

    // top bit moves to bit 32; the low 32 bits are the mantissa fraction
    assign w_sh  = {32'b0, r_x} << (6'd32 - {1'b0, r_e});
    assign w_f   = w_sh[31:0];
    assign w_idx = {1'b0, w_f[31 -: LOG_TABLE_BITS]};
    assign w_a   = w_tbl[w_idx];
    assign w_b   = w_tbl[w_idx + 1'b1];
    assign w_prod = r_diff * r_rem;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_e <= n_e;
            r_x <= i_x;
        end
        if (i_en[1]) begin
            r_e2   <= r_e;
            r_a    <= w_a;
            r_diff <= w_b - w_a;
            r_rem  <= w_f[FRAC_W-1:0];
        end
        if (i_en[2]) begin
            r_lg <= {r_e2, 16'b0} + LG_W'(r_a) + LG_W'(w_prod >> FRAC_W);
        end
    end

    assign o_lg = r_lg;

endmodule

>>> rtl/tocu_div.sv
// ----------------------------------------------------------------------------
// tocu_div: pipelined restoring divider
// One quotient bit per stage; quotient known to fit QBITS bits.
// ----------------------------------------------------------------------------
module tocu_div
    import tocu_pkg::*;
(
    input  logic             i_clk,
    input  logic [QBITS-1:0] i_en,
    input  logic [REM_W-1:0] i_num,
    input  logic [32:0]      i_den,
    output logic [QBITS-1:0] o_quo
);

    logic [REM_W-1:0] r_rem [QBITS];
    logic [32:0]      r_dv  [QBITS];
    logic [QBITS-1:0] r_q   [QBITS];

    for (genvar j = 0; j < QBITS; j++) begin : g_step
        localparam int SH = QBITS - 1 - j;
        logic [REM_W-1:0] w_rin;
        logic [32:0]      w_din;
        logic [QBITS-1:0] w_qin;
        logic [REM_W+1:0] w_trial;
        logic             w_ge;

        if (j == 0) begin : g_first
            assign w_rin = i_num;
            assign w_din = i_den;
            assign w_qin = '0;
        end else begin : g_next
            assign w_rin = r_rem[j-1];
            assign w_din = r_dv[j-1];
            assign w_qin = r_q[j-1];
        end

        assign w_trial = (REM_W+2)'(w_din) << SH;
        assign w_ge    = {2'b0, w_rin} >= w_trial;

        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                r_rem[j] <= w_ge ? REM_W'({2'b0, w_rin} - w_trial) : w_rin;
                r_dv[j]  <= w_din;
                r_q[j]   <= {w_qin[QBITS-2:0], w_ge};
            end
        end
    end

    assign o_quo = r_q[QBITS-1];

endmodule

>>> rtl/tocu_chan.sv
// ----------------------------------------------------------------------------
// tocu_chan: one thermistor channel
// Divider products, two logs, beta-equation denominator, divide, saturate.
// ----------------------------------------------------------------------------
module tocu_chan
    import tocu_pkg::*;
#(
    parameter int SAMPLE_BITS    = 12,
    parameter int LOG_TABLE_BITS = 8
) (
    input  logic                     i_clk,
    input  logic [CH_STAGES-1:0]     i_en,
    input  t_cfg                     i_cfg,
    input  logic signed [TEMP_W-1:0] i_limit,
    input  logic [SAMPLE_W-1:0]      i_sample,
    output logic signed [TEMP_W-1:0] o_temp,
    output logic                     o_fault,
    output logic                     o_over
);

    localparam logic [SAMPLE_W-1:0] SMASK = (SAMPLE_BITS >= SAMPLE_W) ? '1 :
        SAMPLE_W'((1 << SAMPLE_BITS) - 1);

    logic [SAMPLE_W-1:0] w_v;
    logic [31:0]         r_num, r_dn;
    logic [LG_W-1:0]     w_lgn, w_lgd;
    t_res                r_mode  [CH_STAGES-1];
    logic                r_fault [CH_STAGES-1];
    logic signed [22:0]  r_d;
    logic signed [36:0]  r_p1;
    logic signed [53:0]  r_p2;
    logic signed [53:0]  w_adj;
    logic signed [33:0]  w_q;
    logic signed [DEN_W-1:0] r_den;
    logic [28:0]         r_nbt;
    logic [REM_W-1:0]    w_num0;
    logic [QBITS-1:0]    w_quo;
    logic                w_fault0;
    logic                w_den_bad;
    logic signed [14:0]  w_c;
    logic signed [TEMP_W-1:0] n_temp, r_temp;
    logic                r_fault_o, r_over;

    assign w_v      = i_sample & SMASK;
    assign w_fault0 = (w_v == '0) || (w_v >= i_cfg.full_scale);

    tocu_log2 #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_lg_num (
        .i_clk (i_clk),
        .i_en  (i_en[3:1]),
        .i_x   (r_num),
        .o_lg  (w_lgn)
    );

    tocu_log2 #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_lg_den (
        .i_clk (i_clk),
        .i_en  (i_en[3:1]),
        .i_x   (r_dn),
        .o_lg  (w_lgd)
    );

    // truncation toward zero of the scaled log term
    assign w_adj = r_p2 + (r_p2[53] ? 54'sd1048575 : 54'sd0);
    assign w_q   = 34'(w_adj >>> 20);

    // non-positive denominator, or quotient would not fit: saturate hot
    assign w_den_bad = r_den[DEN_W-1] || (r_den == '0) ||
                       ({2'b0, r_nbt, 2'b0} >= r_den[32:0]);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_num      <= 32'(i_cfg.ref_res) * 32'(w_v);
            r_dn       <= 32'(i_cfg.base_res) * 32'(i_cfg.full_scale - w_v);
            r_fault[0] <= w_fault0;
            r_mode[0]  <= (w_fault0 || i_cfg.beta == '0) ? RES_MIN : RES_CALC;
        end
        for (int k = 1; k < CH_STAGES - 1; k++) begin
            if (i_en[k]) begin
                r_fault[k] <= r_fault[k-1];
                if (k == 1 && (r_num == '0 || r_dn == '0)) begin
                    r_mode[k] <= RES_MIN;
                end else if (k == 8 && r_mode[k-1] == RES_CALC && w_den_bad) begin
                    r_mode[k] <= RES_MAX;
                end else begin
                    r_mode[k] <= r_mode[k-1];
                end
            end
        end
        if (i_en[4]) begin
            r_d <= $signed({1'b0, w_lgn}) - $signed({1'b0, w_lgd});
        end
        if (i_en[5]) begin
            r_p1 <= $signed({1'b0, i_cfg.base_temp}) * r_d;
        end
        if (i_en[6]) begin
            r_p2 <= r_p1 * $signed(17'(LN2_Q16));
        end
        if (i_en[7]) begin
            r_den <= $signed({3'b0, i_cfg.beta, 16'b0}) + $signed({w_q[33], w_q});
            r_nbt <= 29'(i_cfg.beta) * 29'(i_cfg.base_temp);
        end
        if (i_en[CH_STAGES-1]) begin
            r_temp    <= n_temp;
            r_fault_o <= r_fault[CH_STAGES-2];
            r_over    <= n_temp > i_limit;
        end
    end

    assign w_num0 = REM_W'({r_nbt, 16'b0});

    tocu_div u_div (
        .i_clk (i_clk),
        .i_en  (i_en[PRE_STAGES +: QBITS]),
        .i_num (w_num0),
        .i_den (r_den[32:0]),
        .o_quo (w_quo)
    );

    assign w_c = $signed({1'b0, w_quo}) - 15'sd4368;

    always_comb begin
        unique case (r_mode[CH_STAGES-2])
            RES_MIN: n_temp = TEMP_W'(TEMP_MIN);
            RES_MAX: n_temp = TEMP_W'(TEMP_MAX);
            default: n_temp = (w_c > 15'sd8191) ? TEMP_W'(TEMP_MAX) : TEMP_W'(w_c);
        endcase
    end

    assign o_temp  = r_temp;
    assign o_fault = r_fault_o;
    assign o_over  = r_over;

endmodule

>>> rtl/thermistor_overtemp_check_unit.sv
// ----------------------------------------------------------------------------
// thermistor_overtemp_check_unit: four-channel NTC over-temperature check
// Beta-equation temperature per channel, fault flags and a board-ok summary.
//
//   port group   dir  contents (lowest bit first)
//   s_axis       in   sample_one..sample_four, 12 bits each
//   m_axis       out  temp_one..temp_four (14 b), fault_one..four, board_ok
//   cfg          in   index 0..5, data up to 20 bits
//
// The pipeline is 8 stages of products, logs and denominator, 14 restoring-divide
// stages (one quotient bit each), a saturate stage and the output register. A
// transaction can enter every cycle unless the pipeline is full and stalled. Each
// stage holds only when its successor is full and stalled, so bubbles close up and
// nothing is lost or repeated. Reset is synchronous and loads the defaults.
// ----------------------------------------------------------------------------
module thermistor_overtemp_check_unit
    import tocu_pkg::*;
#(
    parameter int SAMPLE_BITS    = 12,
    parameter int LOG_TABLE_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [47:0]           i_s_axis_tdata,  // sample_one..sample_four
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [63:0]           o_m_axis_tdata,  // temp_one..four, fault_one..four,
                                                   // board_ok, zero pad
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int NS = CH_STAGES + 1;

    t_cfg                     r_cfg;
    logic signed [TEMP_W-1:0] r_limit;
    logic [NS-1:0]            r_valid;
    logic [NS-1:0]            w_en;
    logic signed [TEMP_W-1:0] w_temp [CH_NUM];
    logic [CH_NUM-1:0]        w_fault, w_over;
    logic signed [TEMP_W-1:0] r_temp [CH_NUM];
    logic [CH_NUM-1:0]        r_fault;
    logic                     r_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ref_res    <= 20'd10000;
            r_cfg.full_scale <= 12'd4095;
            r_cfg.beta       <= 16'd3950;
            r_cfg.base_res   <= 20'd10000;
            r_cfg.base_temp  <= 13'd4770;
            r_limit          <= 14'sd1280;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_REF_RES:    r_cfg.ref_res    <= i_cfg_wdata;
                REG_FULL_SCALE: r_cfg.full_scale <= i_cfg_wdata[11:0];
                REG_BETA:       r_cfg.beta       <= i_cfg_wdata[15:0];
                REG_BASE_RES:   r_cfg.base_res   <= i_cfg_wdata;
                REG_BASE_TEMP:  r_cfg.base_temp  <= i_cfg_wdata[12:0];
                REG_TEMP_LIMIT: r_limit          <= i_cfg_wdata[TEMP_W-1:0];
                default: ;
            endcase
        end
    end

    // a stage loads when it is empty or its contents move on
    always_comb begin
        w_en[NS-1] = !r_valid[NS-1] || i_m_axis_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_valid[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (w_en[k]) r_valid[k] <= (k == 0) ? i_s_axis_tvalid : r_valid[k-1];
            end
        end
    end

    for (genvar c = 0; c < CH_NUM; c++) begin : g_ch
        tocu_chan #(
            .SAMPLE_BITS    (SAMPLE_BITS),
            .LOG_TABLE_BITS (LOG_TABLE_BITS)
        ) u_chan (
            .i_clk    (i_clk),
            .i_en     (w_en[CH_STAGES-1:0]),
            .i_cfg    (r_cfg),
            .i_limit  (r_limit),
            .i_sample (i_s_axis_tdata[c*SAMPLE_W +: SAMPLE_W]),
            .o_temp   (w_temp[c]),
            .o_fault  (w_fault[c]),
            .o_over   (w_over[c])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NS-1]) begin
            for (int c = 0; c < CH_NUM; c++) r_temp[c] <= w_temp[c];
            r_fault <= w_fault;
            r_ok    <= ~|w_over;
        end
    end

    assign o_s_axis_tready = w_en[0];
    assign o_m_axis_tvalid = r_valid[NS-1];
    assign o_m_axis_tdata  = {3'b0, r_ok, r_fault,
                              r_temp[3], r_temp[2], r_temp[1], r_temp[0]};

    a_fault_cold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && r_fault[0] |-> r_temp[0] == TEMP_W'(TEMP_MIN))
        else $error("faulted channel not at minimum temperature");

    a_ok_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> r_ok == !((r_temp[0] > r_limit) || (r_temp[1] > r_limit) ||
                                      (r_temp[2] > r_limit) || (r_temp[3] > r_limit)))
        else $error("board_ok disagrees with channel temperatures");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output stage");

endmodule
